@@ hw/rtl/tfc_pkg.sv @@
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared constants, register map and control types of the temporal frame
// combiner.
// ----------------------------------------------------------------------------
package tfc_pkg;

    // default sizes of the frame ring
    localparam int MAX_SLOTS_DEF        = 8;
    localparam int MAX_FRAME_PIXELS_DEF = 65536;

    // pixel format
    localparam int               PIX_W   = 8;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    // configuration register widths
    localparam int CFG_SLOTS_W = 4;
    localparam int CFG_MODE_W  = 2;
    localparam int CFG_FRAME_W = 17;

    // apb port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    // register indexes (byte address divided by four)
    localparam logic [REG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COMBINE_MODE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_PIXELS = 2'd2;

    // combine modes
    typedef enum logic [CFG_MODE_W-1:0] {
        MODE_MEAN = 2'd0,
        MODE_AND  = 2'd1,
        MODE_OR   = 2'd2,
        MODE_PASS = 2'd3
    } mode_t;

    // register reset values
    localparam logic [CFG_SLOTS_W-1:0] RST_SLOTS_IN_USE = 4'd5;
    localparam mode_t                  RST_COMBINE_MODE = MODE_MEAN;
    localparam logic [CFG_FRAME_W-1:0] RST_FRAME_PIXELS = 17'd65536;

    // register contents as seen by the datapath
    typedef struct packed {
        logic [CFG_SLOTS_W-1:0] slots_in_use;
        mode_t                  combine_mode;
        logic [CFG_FRAME_W-1:0] frame_pixels;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;     // take a pixel, store it, set up the sweep
        logic sweep;      // read the next slot of the ring
        logic div_load;   // load the divider from the sum
        logic div_step;   // one restoring division step
        logic finish;     // load the output register
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic n_zero;     // ring disabled, pixel passes through
        logic mean_mode;  // mean combine selected
        logic sweep_last; // current read is the last slot
        logic div_done;   // current step is the last division step
        logic out_busy;   // output register holds a result not yet taken
    } dp_status_t;

endpackage

@@ hw/rtl/tfc_if.sv @@
// ----------------------------------------------------------------------------
// tfc_if
// Valid/ready stream interfaces for the pixel input and the result output.
// ----------------------------------------------------------------------------

// pixel input stream
interface tfc_pixel_if import tfc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

// combined result stream
interface tfc_result_if import tfc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

@@ hw/rtl/tfc_cfg.sv @@
// ----------------------------------------------------------------------------
// tfc_cfg
// APB register file: slot count, combine mode and frame size, with a restart
// pulse whenever the ring geometry is rewritten.
// ----------------------------------------------------------------------------
module tfc_cfg import tfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg,
    output logic                  restart
);

    logic [CFG_SLOTS_W-1:0] slots_reg, slots_next;
    mode_t                  mode_reg, mode_next;
    logic [CFG_FRAME_W-1:0] frame_reg, frame_next;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // register write decode
    always_comb
    begin
        slots_next = slots_reg;
        mode_next  = mode_reg;
        frame_next = frame_reg;
        restart    = 1'b0;
        if (wr_en)
        begin
            case (reg_idx)
                REG_SLOTS_IN_USE:
                begin
                    slots_next = pwdata[CFG_SLOTS_W-1:0];
                    restart    = 1'b1;
                end
                REG_COMBINE_MODE:
                begin
                    mode_next = mode_t'(pwdata[CFG_MODE_W-1:0]);
                end
                REG_FRAME_PIXELS:
                begin
                    frame_next = pwdata[CFG_FRAME_W-1:0];
                    restart    = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= RST_SLOTS_IN_USE;
            mode_reg  <= RST_COMBINE_MODE;
            frame_reg <= RST_FRAME_PIXELS;
        end
        else
        begin
            slots_reg <= slots_next;
            mode_reg  <= mode_next;
            frame_reg <= frame_next;
        end
    end

    // register read mux
    always_comb
    begin
        case (reg_idx)
            REG_SLOTS_IN_USE: prdata = APB_DATA_W'(slots_reg);
            REG_COMBINE_MODE: prdata = APB_DATA_W'(mode_reg);
            REG_FRAME_PIXELS: prdata = APB_DATA_W'(frame_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.slots_in_use = slots_reg;
    assign cfg.combine_mode = mode_reg;
    assign cfg.frame_pixels = frame_reg;

endmodule

@@ hw/rtl/tfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tfc_ctrl
// Sequencer for one pixel: store, sweep the ring slots when the ring is on,
// divide for the mean, then hand the result to the output register.
// ----------------------------------------------------------------------------
module tfc_ctrl import tfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SWEEP    = 6'b000010,
        S_DRAIN    = 6'b000100,
        S_DIV_LOAD = 6'b001000,
        S_DIV      = 6'b010000,
        S_FINISH   = 6'b100000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.n_zero ? S_FINISH : S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last read data is folded into the accumulators here
                state_next = status.mean_mode ? S_DIV_LOAD : S_FINISH;
            end
            S_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/tfc_datapath.sv @@
// ----------------------------------------------------------------------------
// tfc_datapath
// Frame store, ring pointers, slot accumulators, restoring divider for the
// mean and the output register.
// ----------------------------------------------------------------------------
module tfc_datapath import tfc_pkg::*;
#(
    parameter int MAX_SLOTS        = MAX_SLOTS_DEF,
    parameter int MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             restart,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    input  logic [PIX_W-1:0] pixel_in,
    tfc_result_if.source     result_stream
);

    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int NW        = $clog2(MAX_SLOTS + 1);
    localparam int PW        = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
    localparam int FPW       = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int MEM_DEPTH = MAX_SLOTS * MAX_FRAME_PIXELS;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SUM_W     = PIX_W + NW;
    localparam int DCNT_W    = $clog2(SUM_W);

    // frame store, one region of MAX_FRAME_PIXELS bytes per slot
    logic [PIX_W-1:0] mem [MEM_DEPTH];

    // ring state
    logic [PW-1:0]        pos_reg, pos_next;
    logic [SLOT_W-1:0]    wslot_reg, wslot_next;
    logic [ADDR_W-1:0]    wbase_reg, wbase_next;
    logic [MAX_SLOTS-1:0] slot_valid_reg, slot_valid_next;

    // sweep control
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [ADDR_W-1:0] raddr_reg, raddr_next;
    logic              rd_pend_reg;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [PIX_W-1:0] px_reg;
    logic             last_reg;
    logic [PIX_W-1:0] rdata_reg;
    logic             rd_ok_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [PIX_W-1:0] and_reg;
    logic [PIX_W-1:0] or_reg;
    logic [NW-1:0]    rem_reg;
    logic [SUM_W-1:0] quo_reg;
    logic [PIX_W-1:0] pixel_out_reg;
    logic             frame_last_reg;

    // effective configuration
    logic [31:0]       slots_w;
    logic [31:0]       frame_w;
    logic [NW-1:0]     n_eff;
    logic [FPW-1:0]    fp_eff;
    logic [PW-1:0]     pos_eff;
    logic              last_now;
    logic              wslot_wrap;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;

    // divider step
    logic [NW:0]       div_sh;
    logic              div_ge;

    // rounding and result select
    logic [NW:0]       two_r;
    logic              round_up;
    logic [SUM_W:0]    q_inc;
    logic [PIX_W-1:0]  mean_px;
    logic [PIX_W-1:0]  result_px;

    // clamp slot count and frame size
    assign slots_w = 32'(cfg.slots_in_use);
    assign frame_w = 32'(cfg.frame_pixels);
    assign n_eff   = (slots_w > 32'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : NW'(slots_w);

    always_comb
    begin
        if (frame_w == 32'd0)
        begin
            fp_eff = FPW'(1);
        end
        else if (frame_w > 32'(MAX_FRAME_PIXELS))
        begin
            fp_eff = FPW'(MAX_FRAME_PIXELS);
        end
        else
        begin
            fp_eff = FPW'(frame_w);
        end
    end

    // current position and end of frame
    assign pos_eff    = (FPW'(pos_reg) >= fp_eff) ? '0 : pos_reg;
    assign last_now   = (FPW'(pos_eff) + FPW'(1)) == fp_eff;
    assign wslot_wrap = (NW'(wslot_reg) + NW'(1)) == n_eff;
    assign mem_we     = cmd.accept && (n_eff != '0);
    assign wr_addr    = wbase_reg + ADDR_W'(pos_eff);

    // frame store write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= pixel_in;
        end
        if (cmd.sweep)
        begin
            rdata_reg <= mem[raddr_reg];
        end
    end

    // restoring division step on the sum
    assign div_sh = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge = div_sh >= {1'b0, n_eff};

    // ring pointers, sweep counters and output handshake
    always_comb
    begin
        pos_next        = pos_reg;
        wslot_next      = wslot_reg;
        wbase_next      = wbase_reg;
        slot_valid_next = slot_valid_reg;
        rslot_next      = rslot_reg;
        raddr_next      = raddr_reg;
        dcnt_next       = dcnt_reg;

        if (restart)
        begin
            pos_next        = '0;
            wslot_next      = '0;
            wbase_next      = '0;
            slot_valid_next = '0;
        end
        else if (cmd.accept)
        begin
            pos_next = last_now ? '0 : pos_eff + PW'(1);
            if (n_eff != '0)
            begin
                slot_valid_next[wslot_reg] = 1'b1;
                if (last_now)
                begin
                    wslot_next = wslot_wrap ? '0 : wslot_reg + SLOT_W'(1);
                    wbase_next = wslot_wrap ? '0 : wbase_reg + ADDR_W'(MAX_FRAME_PIXELS);
                end
            end
        end

        if (cmd.accept)
        begin
            rslot_next = '0;
            raddr_next = ADDR_W'(pos_eff);
        end
        else if (cmd.sweep)
        begin
            rslot_next = rslot_reg + SLOT_W'(1);
            raddr_next = raddr_reg + ADDR_W'(MAX_FRAME_PIXELS);
        end

        if (cmd.div_load)
        begin
            dcnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            dcnt_next = dcnt_reg + DCNT_W'(1);
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !result_stream.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            wslot_reg      <= '0;
            wbase_reg      <= '0;
            slot_valid_reg <= '0;
            rslot_reg      <= '0;
            raddr_reg      <= '0;
            rd_pend_reg    <= 1'b0;
            dcnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            wslot_reg      <= wslot_next;
            wbase_reg      <= wbase_next;
            slot_valid_reg <= slot_valid_next;
            rslot_reg      <= rslot_next;
            raddr_reg      <= raddr_next;
            rd_pend_reg    <= cmd.sweep;
            dcnt_reg       <= dcnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // pixel capture, accumulators and divider
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg   <= pixel_in;
            last_reg <= last_now;
            sum_reg  <= '0;
            and_reg  <= PIX_MAX;
            or_reg   <= '0;
        end
        else if (rd_pend_reg && rd_ok_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(rdata_reg);
            and_reg <= and_reg & rdata_reg;
            or_reg  <= or_reg | rdata_reg;
        end

        if (cmd.sweep)
        begin
            rd_ok_reg <= slot_valid_reg[rslot_reg];
        end

        if (cmd.div_load)
        begin
            rem_reg <= '0;
            quo_reg <= sum_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? NW'(div_sh - {1'b0, n_eff}) : NW'(div_sh);
            quo_reg <= {quo_reg[SUM_W-2:0], div_ge};
        end

        if (cmd.finish)
        begin
            pixel_out_reg  <= result_px;
            frame_last_reg <= last_reg;
        end
    end

    // round to nearest, ties to even
    assign two_r    = {rem_reg, 1'b0};
    assign round_up = (two_r > {1'b0, n_eff}) || ((two_r == {1'b0, n_eff}) && quo_reg[0]);
    assign q_inc    = {1'b0, quo_reg} + (SUM_W + 1)'(round_up);
    assign mean_px  = (q_inc > (SUM_W + 1)'(PIX_MAX)) ? PIX_MAX : q_inc[PIX_W-1:0];

    // result select
    always_comb
    begin
        if (n_eff == '0)
        begin
            result_px = px_reg;
        end
        else
        begin
            case (cfg.combine_mode)
                MODE_MEAN: result_px = mean_px;
                MODE_AND:  result_px = and_reg;
                MODE_OR:   result_px = or_reg;
                default:   result_px = px_reg;
            endcase
        end
    end

    // status to the controller
    assign status.n_zero     = (n_eff == '0);
    assign status.mean_mode  = (cfg.combine_mode == MODE_MEAN);
    assign status.sweep_last = (NW'(rslot_reg) + NW'(1)) == n_eff;
    assign status.div_done   = (dcnt_reg == DCNT_W'(SUM_W - 1));
    assign status.out_busy   = out_valid_reg && !result_stream.ready;

    assign result_stream.valid      = out_valid_reg;
    assign result_stream.pixel_out  = pixel_out_reg;
    assign result_stream.frame_last = frame_last_reg;

endmodule

@@ hw/rtl/temporal_frame_combiner.sv @@
// ----------------------------------------------------------------------------
// temporal_frame_combiner
// Combines each greyscale pixel with the same position of the frames kept in
// a ring of frame slots: rounded mean, bitwise AND, bitwise OR or pass-through.
// ----------------------------------------------------------------------------
// Usage
//   pixel_stream carries pixels in raster order, result_stream returns one
//   combined pixel per input pixel, with frame_last on the last pixel of a
//   frame. Both are valid/ready streams; a transaction completes when valid
//   and ready are both high. The APB port sets slot count, combine mode and
//   frame size; writing slot count or frame size restarts the ring.
//   One pixel is processed at a time. Slot count zero disables the ring
//   and passes each pixel through. The single read port of the frame store
//   visits one slot per cycle, and the mean uses a bit-serial divider on
//   SUM_W = 8 + clog2(MAX_SLOTS + 1) bits (12 with 8 slots).
//   A finished result sits in the output register, so the next pixel is
//   taken while the receiver stalls; it then waits until that register frees.
//   Reset clears the ring marks, write slot and pixel position and restores
//   the register defaults; the frame store itself needs no clearing pass.
// ----------------------------------------------------------------------------
module temporal_frame_combiner import tfc_pkg::*;
#(
    parameter int MAX_SLOTS        = MAX_SLOTS_DEF,
    parameter int MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tfc_pixel_if.sink             pixel_stream,
    tfc_result_if.source          result_stream,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t       cfg;
    logic       restart;
    dp_cmd_t    cmd;
    dp_status_t status;

    // configuration registers
    tfc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (restart)
    );

    // sequencer
    tfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel_stream.valid),
        .in_ready (pixel_stream.ready),
        .cmd      (cmd),
        .status   (status)
    );

    // store and arithmetic
    tfc_datapath #(
        .MAX_SLOTS        (MAX_SLOTS),
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .restart       (restart),
        .cmd           (cmd),
        .status        (status),
        .pixel_in      (pixel_stream.pixel_in),
        .result_stream (result_stream)
    );

endmodule

@@ hw/rtl/tfc_checker.sv @@
// ----------------------------------------------------------------------------
// tfc_checker
// Port-level checks of the combiner: output hold under stall, one pixel at a
// time and no result without a pixel taken.
// ----------------------------------------------------------------------------
module tfc_checker import tfc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [PIX_W-1:0] pixel_out,
    input logic             frame_last
);

    logic [1:0] pending_reg, pending_next;
    logic       in_take;
    logic       out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    // pixels taken whose results are not yet delivered
    always_comb
    begin
        pending_next = pending_reg + 2'(in_take) - 2'(out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pixel_out) && $stable(frame_last)))
        else $error("result changed while stalled");

    // a taken pixel is worked on alone
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !in_ready)
        else $error("input ready right after a transaction");

    // no result without a pending pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 2'd0))
        else $error("result without a pixel taken");

    // at most one pixel in work and one result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg != 2'd3))
        else $error("too many pixels in flight");

endmodule

bind temporal_frame_combiner tfc_checker u_tfc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pixel_stream.valid),
    .in_ready   (pixel_stream.ready),
    .out_valid  (result_stream.valid),
    .out_ready  (result_stream.ready),
    .pixel_out  (result_stream.pixel_out),
    .frame_last (result_stream.frame_last)
);
